[hw/rtl/ssds_pkg.sv]
// shared types, constants and segment table for the seven-segment decimal scanner
`timescale 1ns / 1ps

package ssds_pkg;

  localparam int NUM_DIGITS   = 8;
  localparam int CONV_DIGITS  = 8;
  localparam int VALUE_WIDTH  = 32;
  localparam int SCAN_WIDTH   = 3;
  localparam int DRIVE_WIDTH  = 8;
  localparam int SHIFT_STEPS  = VALUE_WIDTH;
  localparam int STEP_WIDTH   = $clog2(SHIFT_STEPS + 1);

  localparam logic [VALUE_WIDTH-1:0] MAX_SHOWN = 32'd99999999;

  typedef logic [3:0] code_t;

  localparam code_t CODE_E     = 4'hE;
  localparam code_t CODE_BLANK = 4'hF;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [VALUE_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic [DRIVE_WIDTH-1:0] anode_drive;
    logic [DRIVE_WIDTH-1:0] segment_drive;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic commit;
    logic set_e;
  } cell_ctrl_t;

  // active-high segments, bit0 a to bit6 g, decimal point off
  function automatic logic [DRIVE_WIDTH-1:0] seg_on(input code_t code);
    logic [DRIVE_WIDTH-1:0] seg;
    case (code)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      CODE_E:  seg = 8'h79;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

[hw/rtl/ssds_digit_cell.sv]
// one decimal digit cell: shift-add-3 conversion step, blanking and display code
`timescale 1ns / 1ps

module ssds_digit_cell (
  input  logic                clk,
  input  logic                rst,
  input  ssds_pkg::cell_ctrl_t ctrl,
  input  logic                units,
  input  logic                carry_in,
  output logic                carry_out,
  input  logic                upper_zero_in,
  output logic                upper_zero_out,
  output ssds_pkg::code_t     disp
);

  ssds_pkg::code_t work;
  ssds_pkg::code_t adj;
  logic            blank;

  always_comb begin
    adj            = (work >= 4'd5) ? work + 4'd3 : work;
    carry_out      = adj[3];
    upper_zero_out = upper_zero_in & (work == 4'd0);
    blank          = upper_zero_out & ~units;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      work <= 4'd0;
    end else if (ctrl.shift) begin
      work <= {adj[2:0], carry_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp <= ssds_pkg::CODE_BLANK;
    end else if (ctrl.set_e) begin
      disp <= ssds_pkg::CODE_E;
    end else if (ctrl.commit) begin
      disp <= blank ? ssds_pkg::CODE_BLANK : work;
    end
  end

endmodule

[hw/rtl/seven_segment_decimal_scanner_unit.sv]
// top level: load sequencing, digit cell chain, anode scan and result register
`timescale 1ns / 1ps

// Eight-digit multiplexed seven-segment driver. In a load beat (req_type 0)
// the value enters a chain of eight digit cells one bit per cycle, most
// significant bit first, then a commit step latches the digits with leading
// zeros blanked; a value above 99999999 sets E in every digit instead.
// A tick beat (req_type 1) yields one result beat with the next active-low
// anode and its cathodes; ticks are held off while a load is in progress
// and while a result waits.
// cfg_wr_en writes last_digit_index, after which the scan wraps to digit 0.
module seven_segment_decimal_scanner_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  ssds_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output ssds_pkg::rsp_t                 rsp,
  input  logic                           cfg_wr_en,
  input  logic [ssds_pkg::SCAN_WIDTH-1:0] cfg_wr_data
);

  logic                                busy;
  logic [ssds_pkg::STEP_WIDTH-1:0]     step;
  logic [ssds_pkg::VALUE_WIDTH-1:0]    value_sr;
  logic [ssds_pkg::SCAN_WIDTH-1:0]     scan_index;
  logic [ssds_pkg::SCAN_WIDTH-1:0]     scan_next;
  logic [ssds_pkg::SCAN_WIDTH-1:0]     last_digit_index;
  logic                                accept;
  logic                                load_go;
  logic                                tick_go;
  logic                                overflow;
  logic                                shifting;
  ssds_pkg::cell_ctrl_t                ctrl;
  ssds_pkg::code_t                     cell_disp [ssds_pkg::CONV_DIGITS];
  logic [ssds_pkg::CONV_DIGITS:0]      carry;
  logic [ssds_pkg::CONV_DIGITS:0]      upper_zero;
  ssds_pkg::code_t                     code;

  assign req_stall = busy | ((req.req_type == ssds_pkg::REQ_TICK) & rsp_valid & rsp_stall);
  assign accept    = req_valid & ~req_stall;
  assign load_go   = accept & (req.req_type == ssds_pkg::REQ_LOAD);
  assign tick_go   = accept & (req.req_type == ssds_pkg::REQ_TICK);
  assign overflow  = req.value > ssds_pkg::MAX_SHOWN;
  assign shifting  = busy & (step != ssds_pkg::STEP_WIDTH'(ssds_pkg::SHIFT_STEPS));

  always_comb begin
    ctrl.clear  = load_go & ~overflow;
    ctrl.shift  = shifting;
    ctrl.commit = busy & ~shifting;
    ctrl.set_e  = load_go & overflow;
  end

  assign carry[0]                        = value_sr[ssds_pkg::VALUE_WIDTH-1];
  assign upper_zero[ssds_pkg::CONV_DIGITS] = 1'b1;

  for (genvar k = 0; k < ssds_pkg::CONV_DIGITS; k++) begin : g_cell
    ssds_digit_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .units          (k == 0),
      .carry_in       (carry[k]),
      .carry_out      (carry[k+1]),
      .upper_zero_in  (upper_zero[k+1]),
      .upper_zero_out (upper_zero[k]),
      .disp           (cell_disp[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load_go & ~overflow) begin
      busy <= 1'b1;
      step <= '0;
    end else if (shifting) begin
      step <= step + 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      value_sr <= req.value;
    end else if (shifting) begin
      value_sr <= {value_sr[ssds_pkg::VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_digit_index <= 3'd7;
    end else if (cfg_wr_en) begin
      last_digit_index <= cfg_wr_data;
    end
  end

  always_comb begin
    scan_next = (scan_index >= last_digit_index) ? '0 : scan_index + 1'b1;
    code      = (32'(scan_next) < 32'(ssds_pkg::NUM_DIGITS)) ? cell_disp[scan_next]
                                                            : ssds_pkg::CODE_BLANK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (tick_go) begin
        scan_index <= scan_next;
        rsp_valid  <= 1'b1;
      end else if (~rsp_stall) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      rsp.anode_drive   <= ~(ssds_pkg::DRIVE_WIDTH'(1) << scan_next);
      rsp.segment_drive <= ~ssds_pkg::seg_on(code);
    end
  end

endmodule
